// ===== hw/rtl/dtm_pkg.sv =====
`timescale 1ns / 1ps
package dtm_pkg;

  typedef enum logic [2:0] {
    REQ_ADD,
    REQ_CANCEL,
    REQ_REFRESH,
    REQ_RESET,
    REQ_EXPIRE,
    REQ_NEXT
  } req_t;

  typedef enum logic [1:0] {
    KIND_ACK,
    KIND_EXPIRED,
    KIND_NONE,
    KIND_NEXT
  } kind_t;

  typedef enum logic [1:0] {
    SCAN_MIN_ACT,
    SCAN_MIN_DUE,
    SCAN_DUE,
    SCAN_UPD
  } scan_mode_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_EXEC,
    S_SCAN_FRONT,
    S_FRONT,
    S_EMIT_ACK,
    S_EXP0,
    S_SCAN_DUE,
    S_DUE_CHK,
    S_EMIT_NONE,
    S_SCAN_EXP,
    S_EMIT_EXP,
    S_SCAN_UPD,
    S_SCAN_NEXT,
    S_EMIT_NEXT
  } state_t;

  localparam logic [31:0] WINDOW_RESET = 32'd3600000;

  typedef struct packed {
    logic       load;
    logic       exec;
    logic       scan_start;
    scan_mode_t scan_mode;
    logic       front_chk;
    logic       exp_init;
    logic       emit;
    kind_t      emit_kind;
  } dp_cmd_t;

  typedef struct packed {
    req_t req;
    logic tid_valid;
    logic need_front;
    logic any_active;
    logic any_due;
    logic more_due;
    logic scan_done;
    logic out_free;
  } dp_sts_t;

endpackage

// ===== hw/rtl/dtm_if.sv =====
`timescale 1ns / 1ps
interface dtm_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [3:0]  timer_id;
  logic [31:0] period;
  logic        recurring;
  logic        restart;
  logic [63:0] now_time;

  modport source (output valid, req_type, timer_id, period, recurring, restart, now_time,
                  input ready);
  modport sink (input valid, req_type, timer_id, period, recurring, restart, now_time,
                output ready);
endinterface

interface dtm_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [3:0]  expired_id;
  logic        ok;
  logic        front_changed;
  logic [63:0] duration;
  logic        no_next;
  logic        last;

  modport source (output valid, kind, expired_id, ok, front_changed, duration, no_next, last,
                  input ready);
  modport sink (input valid, kind, expired_id, ok, front_changed, duration, no_next, last,
                output ready);
endinterface

// ===== hw/rtl/dtm_datapath.sv =====
`timescale 1ns / 1ps
module dtm_datapath #(
  parameter int NUM_TIMERS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  dtm_pkg::dp_cmd_t  cmd,
  output dtm_pkg::dp_sts_t  sts,
  input  logic [2:0]        in_req_type,
  input  logic [3:0]        in_timer_id,
  input  logic [31:0]       in_period,
  input  logic              in_recurring,
  input  logic              in_restart,
  input  logic [63:0]       in_now_time,
  input  logic              cfg_wr_en,
  input  logic [31:0]       cfg_wr_data,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [1:0]        out_kind,
  output logic [3:0]        out_expired_id,
  output logic              out_ok,
  output logic              out_front_changed,
  output logic [63:0]       out_duration,
  output logic              out_no_next,
  output logic              out_last
);
  import dtm_pkg::*;

  localparam int IDW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam logic [IDW-1:0] LAST_IDX = IDW'(NUM_TIMERS - 1);

  req_t            req_r;
  logic [3:0]      tid_r;
  logic [31:0]     per_r;
  logic            rec_r;
  logic            fnow_r;
  logic [63:0]     now_r;
  logic [31:0]     window_r;
  logic [63:0]     prev_r;
  logic            roll_r;
  logic            notice_r;
  logic            ok_r;
  logic            fc_r;
  logic [NUM_TIMERS-1:0] active_r;
  logic [NUM_TIMERS-1:0] recur_r;
  logic [NUM_TIMERS-1:0] due_r;
  logic [NUM_TIMERS-1:0] done_r;
  logic [IDW-1:0]  idx_r;
  logic            run_r;
  logic            pvld_r;
  logic [IDW-1:0]  pidx_r;
  scan_mode_t      mode_r;
  logic            best_vld_r;
  logic [IDW-1:0]  best_r;
  logic [63:0]     best_dl_r;
  logic [31:0]     per_mem [NUM_TIMERS];
  logic [63:0]     dl_mem [NUM_TIMERS];
  logic [31:0]     rd_per_r;
  logic [63:0]     rd_dl_r;
  logic            out_valid_r;

  logic [IDW-1:0]  slot;
  logic [IDW-1:0]  rd_addr;
  logic            wr_en;
  logic            wr_per_en;
  logic [IDW-1:0]  wr_addr;
  logic [63:0]     wr_dl;
  logic            chg;
  logic            need_front;
  logic            cand;
  logic [NUM_TIMERS-1:0] best_oh;

  assign slot    = IDW'(tid_r);
  assign rd_addr = run_r ? idx_r : slot;

  always_comb begin
    best_oh = '0;
    best_oh[best_r] = 1'b1;
    chg = active_r[slot] && !((per_r == rd_per_r) && !fnow_r);
    wr_en = 1'b0;
    wr_per_en = 1'b0;
    wr_addr = slot;
    wr_dl = now_r + 64'(per_r);
    need_front = 1'b0;
    case (req_r)
      REQ_ADD: begin
        need_front = 1'b1;
        wr_en = cmd.exec;
        wr_per_en = cmd.exec;
      end
      REQ_REFRESH: begin
        wr_en = cmd.exec && active_r[slot];
        wr_dl = now_r + 64'(rd_per_r);
      end
      REQ_RESET: begin
        need_front = chg;
        wr_en = cmd.exec && chg;
        wr_per_en = cmd.exec && chg;
        wr_dl = fnow_r ? now_r + 64'(per_r) : rd_dl_r + 64'(per_r) - 64'(rd_per_r);
      end
      default: begin
      end
    endcase
    if (pvld_r && mode_r == SCAN_UPD && due_r[pidx_r] && recur_r[pidx_r]) begin
      wr_en = 1'b1;
      wr_per_en = 1'b0;
      wr_addr = pidx_r;
      wr_dl = now_r + 64'(rd_per_r);
    end
    cand = (mode_r == SCAN_MIN_ACT) ? active_r[pidx_r] : (due_r[pidx_r] && !done_r[pidx_r]);
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      dl_mem[wr_addr] <= wr_dl;
      if (wr_per_en) begin
        per_mem[wr_addr] <= per_r;
      end
    end
    rd_dl_r  <= dl_mem[rd_addr];
    rd_per_r <= per_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r  <= req_t'(in_req_type);
      tid_r  <= in_timer_id;
      per_r  <= in_period;
      rec_r  <= in_recurring;
      fnow_r <= in_restart;
      now_r  <= in_now_time;
    end
    pidx_r <= idx_r;
    if (pvld_r && (mode_r == SCAN_MIN_ACT || mode_r == SCAN_MIN_DUE) && cand &&
        (!best_vld_r || rd_dl_r < best_dl_r)) begin
      best_r    <= pidx_r;
      best_dl_r <= rd_dl_r;
    end
    if (pvld_r && mode_r == SCAN_DUE) begin
      due_r[pidx_r] <= active_r[pidx_r] && (roll_r || rd_dl_r <= now_r);
    end
    if (cmd.exp_init) begin
      roll_r <= (now_r < prev_r) && ((prev_r - now_r) > 64'(window_r));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      pvld_r <= 1'b0;
      idx_r <= '0;
      mode_r <= SCAN_MIN_ACT;
      best_vld_r <= 1'b0;
      active_r <= '0;
      recur_r <= '0;
      done_r <= '0;
      prev_r <= '0;
      notice_r <= 1'b0;
      ok_r <= 1'b0;
      fc_r <= 1'b0;
      window_r <= WINDOW_RESET;
    end else begin
      pvld_r <= run_r;
      if (cfg_wr_en) begin
        window_r <= cfg_wr_data;
      end
      if (cmd.scan_start) begin
        run_r <= 1'b1;
        idx_r <= '0;
        mode_r <= cmd.scan_mode;
        best_vld_r <= 1'b0;
      end else if (run_r) begin
        if (idx_r == LAST_IDX) begin
          run_r <= 1'b0;
        end else begin
          idx_r <= idx_r + 1'b1;
        end
      end
      if (pvld_r && (mode_r == SCAN_MIN_ACT || mode_r == SCAN_MIN_DUE) && cand) begin
        best_vld_r <= 1'b1;
      end
      if (pvld_r && mode_r == SCAN_UPD && due_r[pidx_r] && !recur_r[pidx_r]) begin
        active_r[pidx_r] <= 1'b0;
      end
      if (cmd.load) begin
        ok_r <= 1'b0;
        fc_r <= 1'b0;
      end
      if (cmd.exec) begin
        case (req_r)
          REQ_ADD: begin
            active_r[slot] <= 1'b1;
            recur_r[slot] <= rec_r;
            ok_r <= 1'b1;
          end
          REQ_CANCEL: begin
            ok_r <= active_r[slot];
            active_r[slot] <= 1'b0;
          end
          REQ_REFRESH: ok_r <= active_r[slot];
          default: ok_r <= 1'b1;
        endcase
      end
      if (cmd.front_chk && best_vld_r && best_r == slot && !notice_r) begin
        notice_r <= 1'b1;
        fc_r <= 1'b1;
      end
      if (cmd.exp_init) begin
        prev_r <= now_r;
        done_r <= '0;
      end
      if (cmd.emit && cmd.emit_kind == KIND_EXPIRED) begin
        done_r[best_r] <= 1'b1;
      end
      if (cmd.emit && cmd.emit_kind == KIND_NEXT) begin
        notice_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_kind <= cmd.emit_kind;
      out_expired_id <= 4'd0;
      out_ok <= 1'b0;
      out_front_changed <= 1'b0;
      out_duration <= 64'd0;
      out_no_next <= 1'b0;
      out_last <= 1'b1;
      case (cmd.emit_kind)
        KIND_ACK: begin
          out_expired_id <= tid_r;
          out_ok <= ok_r;
          out_front_changed <= fc_r;
        end
        KIND_EXPIRED: begin
          out_expired_id <= 4'(best_r);
          out_last <= !sts.more_due;
        end
        KIND_NEXT: begin
          out_no_next <= !best_vld_r;
          if (best_vld_r && now_r < best_dl_r) begin
            out_duration <= best_dl_r - now_r;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;

  assign sts.req        = req_r;
  assign sts.tid_valid  = 32'(tid_r) < 32'(NUM_TIMERS);
  assign sts.need_front = need_front;
  assign sts.any_active = |active_r;
  assign sts.any_due    = |due_r;
  assign sts.more_due   = |(due_r & ~done_r & ~best_oh);
  assign sts.scan_done  = pvld_r && (pidx_r == LAST_IDX);
  assign sts.out_free   = !out_valid_r || out_ready;

endmodule

// ===== hw/rtl/dtm_ctrl.sv =====
`timescale 1ns / 1ps
module dtm_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output dtm_pkg::dp_cmd_t cmd,
  input  dtm_pkg::dp_sts_t sts
);
  import dtm_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    cmd.scan_mode = SCAN_MIN_ACT;
    cmd.emit_kind = KIND_ACK;
    in_ready = (state_r == S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.req == REQ_EXPIRE) begin
          state_nxt = S_EXP0;
        end else if (sts.req == REQ_NEXT) begin
          cmd.scan_start = 1'b1;
          cmd.scan_mode = SCAN_MIN_ACT;
          state_nxt = S_SCAN_NEXT;
        end else if (!sts.tid_valid || !(sts.req == REQ_ADD || sts.req == REQ_CANCEL ||
                     sts.req == REQ_REFRESH || sts.req == REQ_RESET)) begin
          state_nxt = S_EMIT_ACK;
        end else begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (sts.need_front) begin
          cmd.scan_start = 1'b1;
          cmd.scan_mode = SCAN_MIN_ACT;
          state_nxt = S_SCAN_FRONT;
        end else begin
          state_nxt = S_EMIT_ACK;
        end
      end
      S_SCAN_FRONT: if (sts.scan_done) state_nxt = S_FRONT;
      S_FRONT: begin
        cmd.front_chk = 1'b1;
        state_nxt = S_EMIT_ACK;
      end
      S_EMIT_ACK: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          cmd.emit_kind = KIND_ACK;
          state_nxt = S_IDLE;
        end
      end
      S_EXP0: begin
        if (sts.any_active) begin
          cmd.exp_init = 1'b1;
          cmd.scan_start = 1'b1;
          cmd.scan_mode = SCAN_DUE;
          state_nxt = S_SCAN_DUE;
        end else begin
          state_nxt = S_EMIT_NONE;
        end
      end
      S_SCAN_DUE: if (sts.scan_done) state_nxt = S_DUE_CHK;
      S_DUE_CHK: begin
        if (sts.any_due) begin
          cmd.scan_start = 1'b1;
          cmd.scan_mode = SCAN_MIN_DUE;
          state_nxt = S_SCAN_EXP;
        end else begin
          state_nxt = S_EMIT_NONE;
        end
      end
      S_EMIT_NONE: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          cmd.emit_kind = KIND_NONE;
          state_nxt = S_IDLE;
        end
      end
      S_SCAN_EXP: if (sts.scan_done) state_nxt = S_EMIT_EXP;
      S_EMIT_EXP: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          cmd.emit_kind = KIND_EXPIRED;
          cmd.scan_start = 1'b1;
          if (sts.more_due) begin
            cmd.scan_mode = SCAN_MIN_DUE;
            state_nxt = S_SCAN_EXP;
          end else begin
            cmd.scan_mode = SCAN_UPD;
            state_nxt = S_SCAN_UPD;
          end
        end
      end
      S_SCAN_UPD: if (sts.scan_done) state_nxt = S_IDLE;
      S_SCAN_NEXT: if (sts.scan_done) state_nxt = S_EMIT_NEXT;
      S_EMIT_NEXT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          cmd.emit_kind = KIND_NEXT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> sts.out_free)
    else $error("result written while the output beat is still held");

  a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_DECODE))
    else $error("accepted request not decoded");

  a_scan_state: assert property (@(posedge clk) disable iff (!rst_n)
    sts.scan_done |-> (state_r == S_SCAN_FRONT || state_r == S_SCAN_DUE ||
                       state_r == S_SCAN_EXP || state_r == S_SCAN_UPD ||
                       state_r == S_SCAN_NEXT))
    else $error("slot scan finished outside a scan state");

endmodule

// ===== hw/rtl/deadline_timer_manager.sv =====
// Cancel, refresh and an unchanged reset are acknowledged without a slot scan; a bad request skips execution.
// Add and a deadline-moving reset also scan for the earliest slot before the acknowledge.
// Next duration scans for the earliest active slot; an expire scans for due slots, then once per
// due slot to report the earliest, then updates them; each scan checks one slot per cycle.
// A new request is taken once the previous one is finished; results leave through a register.
// Synchronous reset clears control, marks and times; period and deadline memory are not cleared.
`timescale 1ns / 1ps
module deadline_timer_manager #(
  parameter int NUM_TIMERS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  dtm_req_if.sink    in_req,
  dtm_res_if.source  out_res,
  input  logic       cfg_wr_en,
  input  logic [31:0] cfg_wr_data
);
  import dtm_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  dtm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (in_req.ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  dtm_datapath #(
    .NUM_TIMERS (NUM_TIMERS)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_req_type       (in_req.req_type),
    .in_timer_id       (in_req.timer_id),
    .in_period         (in_req.period),
    .in_recurring      (in_req.recurring),
    .in_restart        (in_req.restart),
    .in_now_time       (in_req.now_time),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .out_ready         (out_res.ready),
    .out_valid         (out_res.valid),
    .out_kind          (out_res.kind),
    .out_expired_id    (out_res.expired_id),
    .out_ok            (out_res.ok),
    .out_front_changed (out_res.front_changed),
    .out_duration      (out_res.duration),
    .out_no_next       (out_res.no_next),
    .out_last          (out_res.last)
  );

endmodule

// ===== tb/tb_deadline_timer_manager.sv =====
`timescale 1ns / 1ps
module tb_deadline_timer_manager;
  import dtm_pkg::*;

  localparam logic [2:0] REQ_UNUSED_A = 3'd6;
  localparam logic [2:0] REQ_UNUSED_B = 3'd7;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  expired_id;
    logic        ok;
    logic        front_changed;
    logic [63:0] duration;
    logic        no_next;
    logic        last;
  } res_t;

  int errors = 0;

  task automatic report(input string what, input res_t got, input res_t exp);
    $display("mismatch %s: got %p expected %p", what, got, exp);
    errors++;
  endtask

  class timer_scoreboard;
    bit          act[16];
    bit          rec[16];
    logic [31:0] per[16];
    logic [63:0] dl[16];
    logic [63:0] prev_time;
    bit          pending;
    logic [31:0] window;
    res_t        pend_q[$];

    function new();
      prev_time = 0;
      pending = 0;
      window = WINDOW_RESET;
      foreach (act[i]) begin
        act[i] = 0;
        rec[i] = 0;
        per[i] = 0;
        dl[i] = 0;
      end
    endfunction

    function int earliest();
      int b;
      b = -1;
      for (int i = 0; i < 16; i++)
        if (act[i] && (b < 0 || dl[i] < dl[b])) b = i;
      return b;
    endfunction

    function bit notice(int s);
      if (earliest() == s && !pending) begin
        pending = 1;
        return 1;
      end
      return 0;
    endfunction

    function void push(logic [1:0] k, logic [3:0] id, bit ok, bit fc, logic [63:0] d,
                       bit nn, bit lst);
      res_t r;
      r.kind = k;
      r.expired_id = id;
      r.ok = ok;
      r.front_changed = fc;
      r.duration = d;
      r.no_next = nn;
      r.last = lst;
      pend_q.push_back(r);
    endfunction

    function void note_request(logic [2:0] rq, logic [3:0] id, logic [31:0] p, bit r,
                               bit fn, logic [63:0] now);
      bit due[16];
      bit done[16];
      int n, b, e;
      bit roll;
      if (rq == REQ_EXPIRE) begin
        if (earliest() < 0) begin
          push(KIND_NONE, 0, 0, 0, 0, 0, 1);
          return;
        end
        roll = now < prev_time && (prev_time - now) > {32'd0, window};
        prev_time = now;
        n = 0;
        for (int i = 0; i < 16; i++) begin
          due[i] = act[i] && (roll || dl[i] <= now);
          done[i] = 0;
          if (due[i]) n++;
        end
        if (n == 0) begin
          push(KIND_NONE, 0, 0, 0, 0, 0, 1);
          return;
        end
        for (int k = 0; k < n; k++) begin
          b = -1;
          for (int i = 0; i < 16; i++)
            if (due[i] && !done[i] && (b < 0 || dl[i] < dl[b])) b = i;
          done[b] = 1;
          push(KIND_EXPIRED, b[3:0], 0, 0, 0, 0, k == n - 1);
        end
        for (int i = 0; i < 16; i++)
          if (due[i]) begin
            if (rec[i]) dl[i] = now + per[i];
            else act[i] = 0;
          end
        return;
      end
      if (rq == REQ_NEXT) begin
        e = earliest();
        pending = 0;
        if (e < 0) push(KIND_NEXT, 0, 0, 0, 0, 1, 1);
        else push(KIND_NEXT, 0, 0, 0, now >= dl[e] ? 64'd0 : dl[e] - now, 0, 1);
        return;
      end
      if (rq > REQ_NEXT) begin
        push(KIND_ACK, id, 0, 0, 0, 0, 1);
        return;
      end
      case (rq)
        REQ_ADD: begin
          act[id] = 1;
          rec[id] = r;
          per[id] = p;
          dl[id] = now + p;
          push(KIND_ACK, id, 1, notice(id), 0, 0, 1);
        end
        REQ_CANCEL: begin
          push(KIND_ACK, id, act[id], 0, 0, 0, 1);
          act[id] = 0;
        end
        REQ_REFRESH: begin
          if (act[id]) dl[id] = now + per[id];
          push(KIND_ACK, id, act[id], 0, 0, 0, 1);
        end
        default: begin
          if (!act[id] || (p == per[id] && !fn)) begin
            push(KIND_ACK, id, 1, 0, 0, 0, 1);
          end else begin
            if (fn) dl[id] = now + p;
            else dl[id] = dl[id] + p - per[id];
            per[id] = p;
            push(KIND_ACK, id, 1, notice(id), 0, 0, 1);
          end
        end
      endcase
    endfunction

    task check_result(res_t got);
      res_t exp;
      if (pend_q.size() == 0) begin
        report("unexpected beat", got, got);
        return;
      end
      exp = pend_q.pop_front();
      if (got.kind != exp.kind) report("kind", got, exp);
      if (got.expired_id != exp.expired_id) report("expired_id", got, exp);
      if (got.ok != exp.ok) report("ok", got, exp);
      if (got.front_changed != exp.front_changed) report("front_changed", got, exp);
      if (got.duration != exp.duration) report("duration", got, exp);
      if (got.no_next != exp.no_next) report("no_next", got, exp);
      if (got.last != exp.last) report("last", got, exp);
    endtask
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_wr_en = 0;
  logic [31:0] cfg_wr_data = 0;
  int src_idle = 0;
  int snk_idle = 0;
  longint cycles = 0;
  logic [63:0] now_base = 0;

  dtm_req_if in_req();
  dtm_res_if out_res();

  deadline_timer_manager uut (
    .clk(clk), .rst_n(rst_n), .in_req(in_req.sink), .out_res(out_res.source),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  timer_scoreboard sb = new();

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    in_req.valid = 0;
    in_req.req_type = 0;
    in_req.timer_id = 0;
    in_req.period = 0;
    in_req.recurring = 0;
    in_req.restart = 0;
    in_req.now_time = 0;
    out_res.ready = 0;
  end

  always @(posedge clk) begin
    res_t r;
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("CHECK FAILED");
      $finish;
    end
    if (rst_n && out_res.valid && out_res.ready) begin
      r.kind = out_res.kind;
      r.expired_id = out_res.expired_id;
      r.ok = out_res.ok;
      r.front_changed = out_res.front_changed;
      r.duration = out_res.duration;
      r.no_next = out_res.no_next;
      r.last = out_res.last;
      sb.check_result(r);
    end
    out_res.ready <= ($urandom_range(99) >= snk_idle);
  end

  task automatic send(logic [2:0] rq, logic [3:0] id, logic [31:0] p, bit r, bit fn,
                      logic [63:0] now);
    while ($urandom_range(99) < src_idle) begin
      in_req.valid <= 0;
      @(posedge clk);
    end
    in_req.valid <= 1;
    in_req.req_type <= rq;
    in_req.timer_id <= id;
    in_req.period <= p;
    in_req.recurring <= r;
    in_req.restart <= fn;
    in_req.now_time <= now;
    @(posedge clk);
    while (!in_req.ready) @(posedge clk);
    sb.note_request(rq, id, p, r, fn, now);
  endtask

  task automatic drain();
    in_req.valid <= 0;
    while (sb.pend_q.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_window(logic [31:0] w);
    drain();
    cfg_wr_en <= 1;
    cfg_wr_data <= w;
    @(posedge clk);
    cfg_wr_en <= 0;
    sb.window = w;
  endtask

  function automatic logic [31:0] rand_period();
    case ($urandom_range(5))
      0: return 0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom;
      default: return $urandom_range(200);
    endcase
  endfunction

  task automatic random_items(int count);
    logic [2:0] rq;
    logic [63:0] now;
    for (int i = 0; i < count; i++) begin
      rq = $urandom_range(99) < 3 ? 3'($urandom_range(7)) : 3'($urandom_range(5));
      if ($urandom_range(19) == 0) now = {$urandom, $urandom};
      else if ($urandom_range(9) == 0 && now_base > 64'd5000) now = now_base - $urandom_range(8000);
      else begin
        now_base = now_base + $urandom_range(60);
        now = now_base;
      end
      send(rq, 4'($urandom_range(15)), rand_period(), 1'($urandom_range(1)),
           1'($urandom_range(1)), now);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    src_idle = 0;
    snk_idle = 0;
    send(REQ_EXPIRE, 0, 0, 0, 0, 0);
    send(REQ_NEXT, 0, 0, 0, 0, 0);
    send(REQ_CANCEL, 3, 0, 0, 0, 0);
    send(REQ_REFRESH, 3, 0, 0, 0, 0);
    send(REQ_RESET, 3, 5, 0, 1, 0);
    send(REQ_ADD, 0, 10, 1, 0, 100);
    send(REQ_ADD, 15, 10, 0, 0, 100);
    send(REQ_ADD, 7, 32'hFFFF_FFFF, 0, 0, 64'hFFFF_FFFF_FFFF_FFF0);
    send(REQ_ADD, 5, 0, 0, 0, 100);
    send(REQ_NEXT, 0, 0, 0, 0, 105);
    send(REQ_NEXT, 0, 0, 0, 0, 50);
    send(REQ_RESET, 0, 10, 0, 0, 100);
    send(REQ_RESET, 0, 20, 0, 0, 100);
    send(REQ_RESET, 15, 3, 0, 1, 100);
    send(REQ_REFRESH, 5, 0, 0, 0, 101);
    send(REQ_EXPIRE, 0, 0, 0, 0, 50);
    send(REQ_EXPIRE, 0, 0, 0, 0, 200);
    send(REQ_UNUSED_A, 2, 0, 0, 0, 0);
    send(REQ_UNUSED_B, 9, 0, 0, 0, 0);
    send(REQ_ADD, 1, 100, 1, 0, 64'hFFFF_FFFF_0000_0000);
    send(REQ_EXPIRE, 0, 0, 0, 0, 64'hFFFF_FFFF_0000_0000);
    write_window(0);
    send(REQ_EXPIRE, 0, 0, 0, 0, 64'hFFFF_FFFE_FFFF_FFFF);
    send(REQ_CANCEL, 1, 0, 0, 0, 0);
    send(REQ_CANCEL, 7, 0, 0, 0, 0);
    drain();
    src_idle = 14;
    snk_idle = 53;
    random_items(140);
    write_window(32'hFFFF_FFFF);
    src_idle = 53;
    snk_idle = 14;
    random_items(140);
    write_window($urandom_range(10000));
    src_idle = 0;
    snk_idle = 0;
    random_items(140);
    write_window(WINDOW_RESET);
    random_items(10);
    drain();
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

// ===== files.f =====
hw/rtl/dtm_pkg.sv
hw/rtl/dtm_if.sv
hw/rtl/dtm_datapath.sv
hw/rtl/dtm_ctrl.sv
hw/rtl/deadline_timer_manager.sv
tb/tb_deadline_timer_manager.sv
